// ===== rtl/core/cqkr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqkr_pkg: shared types and constants for the keyed-remove circular queue
// Holds the transaction payload types, request codes, register indexes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cqkr_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int REQ_W   = 3;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 5;
  localparam int CAP_RESET = 16;

  // Request codes carried in req_type.
  localparam logic [REQ_W-1:0] REQ_ENQUEUE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK_FIRST = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK_LAST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE_KEY = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_MATCH_MASK = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] data_in;
    logic [DATA_W-1:0] key;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  fill_count;
  } out_item_t;

  // Read address selection for the slot memory.
  typedef enum logic [1:0] {
    RD_HEAD  = 2'd0,
    RD_TAIL  = 2'd1,
    RD_NEXT  = 2'd2,
    RD_NEXT2 = 2'd3
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ld_req;     // capture the accepted request
    logic    enq;        // append data_in at the tail
    logic    rd_en;      // issue a slot read
    rd_sel_t rd_sel;     // which slot to read
    logic    scan_init;  // start a key search at the head
    logic    scan_adv;   // step the search to the next slot
    logic    capture;    // take the read word as a successful result
    logic    fail;       // mark the result as failed
    logic    deq;        // drop the front entry
    logic    shift;      // move the read word one slot toward the front
    logic    retreat;    // pull the tail back after a removal
    logic    out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             empty;
    logic             full;
    logic             match;
    logic             scan_last;
    logic             at_tail;
    logic             shift_last;
  } sts_t;

endpackage

// ===== rtl/core/cqkr_ram.sv =====
// ----------------------------------------------------------------------------
// cqkr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cqkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cqkr_dp.sv =====
// ----------------------------------------------------------------------------
// cqkr_dp: queue datapath
// Holds the configuration registers, ring pointers, fill count, search
// pointer, result register, and drives the slot memory ports.
// ----------------------------------------------------------------------------
module cqkr_dp #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic                                     cfg_index,
  input  logic [cqkr_pkg::DATA_W-1:0]              cfg_data,
  input  cqkr_pkg::in_item_t                       in_item,
  input  cqkr_pkg::cmd_t                           cmd,
  output cqkr_pkg::sts_t                           sts,
  output cqkr_pkg::out_item_t                      out_item,
  output logic                                     ram_we,
  output logic [$clog2(DEPTH)-1:0]                 ram_waddr,
  output logic [WORD_BITS-1:0]                     ram_wdata,
  output logic                                     ram_re,
  output logic [$clog2(DEPTH)-1:0]                 ram_raddr,
  input  logic [WORD_BITS-1:0]                     ram_rdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = cqkr_pkg::CNT_W;
  localparam int XW    = ((AW > CW) ? AW : CW) + 1;
  localparam int CAP_MAX = (1 << CW) - 1;
  localparam logic [CW-1:0] RST_CAP =
    CW'((DEPTH < cqkr_pkg::CAP_RESET) ? DEPTH : cqkr_pkg::CAP_RESET);
  localparam logic [CW-1:0] DEPTH_CAP = CW'((DEPTH < CAP_MAX) ? DEPTH : CAP_MAX);

  // Slot index after i, wrapping at the capacity in use.
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i,
                                              input logic [CW-1:0] cap);
    logic [XW-1:0] inc;
    inc = XW'(i) + XW'(1);
    return (inc >= XW'(cap)) ? '0 : AW'(inc);
  endfunction

  // Slot index before i, wrapping at the capacity in use.
  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i,
                                              input logic [CW-1:0] cap);
    return (i == '0) ? AW'(cap - 1'b1) : i - 1'b1;
  endfunction

  logic [CW-1:0]               cap_r, cap_nxt;
  logic [cqkr_pkg::DATA_W-1:0] mask_r, mask_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [AW-1:0]               tail_r, tail_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]               scan_n_r, scan_n_nxt;
  cqkr_pkg::in_item_t          req_r;
  logic                        res_ok_r;
  logic [cqkr_pkg::DATA_W-1:0] res_data_r;
  cqkr_pkg::out_item_t         out_r;

  logic                        cfg_we;
  logic [CW-1:0]               cap_wr;
  logic [AW-1:0]               tail_inc;
  logic [AW-1:0]               scan_next;
  logic [cqkr_pkg::DATA_W-1:0] rd_word;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign tail_inc  = next_slot(tail_r, cap_r);
  assign scan_next = next_slot(scan_ptr_r, cap_r);
  assign rd_word   = cqkr_pkg::DATA_W'(ram_rdata);

  // Capacity write value: zero is taken as one, larger than storage as storage.
  always_comb begin
    cap_wr = cfg_data[CW-1:0];
    if (cap_wr == '0) begin
      cap_wr = CW'(1);
    end else if (32'(cap_wr) > DEPTH) begin
      cap_wr = DEPTH_CAP;
    end
  end

  // Next state of the queue bookkeeping.
  always_comb begin
    cap_nxt   = cap_r;
    mask_nxt  = mask_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cfg_we && cfg_index == cqkr_pkg::CFG_CAPACITY) begin
      cap_nxt   = cap_wr;
      head_nxt  = '0;
      tail_nxt  = AW'(cap_wr - 1'b1);
      count_nxt = '0;
    end
    if (cfg_we && cfg_index == cqkr_pkg::CFG_MATCH_MASK) begin
      mask_nxt = cfg_data;
    end
    if (cmd.enq) begin
      tail_nxt  = tail_inc;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.deq) begin
      head_nxt  = next_slot(head_r, cap_r);
      count_nxt = count_r - 1'b1;
    end
    if (cmd.retreat) begin
      tail_nxt  = prev_slot(tail_r, cap_r);
      count_nxt = count_r - 1'b1;
    end
  end

  // Search pointer and position counter.
  always_comb begin
    scan_ptr_nxt = scan_ptr_r;
    scan_n_nxt   = scan_n_r;
    if (cmd.scan_init) begin
      scan_ptr_nxt = head_r;
      scan_n_nxt   = '0;
    end else if (cmd.scan_adv) begin
      scan_ptr_nxt = scan_next;
      scan_n_nxt   = scan_n_r + 1'b1;
    end else if (cmd.shift) begin
      scan_ptr_nxt = scan_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= RST_CAP;
      mask_r     <= '1;
      head_r     <= '0;
      tail_r     <= AW'(RST_CAP - 1'b1);
      count_r    <= '0;
      scan_ptr_r <= '0;
      scan_n_r   <= '0;
    end else begin
      cap_r      <= cap_nxt;
      mask_r     <= mask_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      scan_n_r   <= scan_n_nxt;
    end
  end

  // Request, result and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r <= in_item;
    end
    if (cmd.enq) begin
      res_ok_r   <= 1'b1;
      res_data_r <= '0;
    end else if (cmd.capture) begin
      res_ok_r   <= 1'b1;
      res_data_r <= rd_word;
    end else if (cmd.fail) begin
      res_ok_r   <= 1'b0;
      res_data_r <= '0;
    end
    if (cmd.out_load) begin
      out_r.ok         <= res_ok_r;
      out_r.data_out   <= res_data_r;
      out_r.fill_count <= count_r;
    end
  end

  assign out_item = out_r;

  // Slot memory write port: appended word or shifted entry.
  always_comb begin
    ram_we    = cmd.enq || cmd.shift;
    ram_waddr = cmd.shift ? scan_ptr_r : tail_inc;
    ram_wdata = cmd.shift ? ram_rdata : WORD_BITS'(req_r.data_in);
  end

  // Slot memory read port.
  always_comb begin
    ram_re = cmd.rd_en;
    case (cmd.rd_sel)
      cqkr_pkg::RD_HEAD:  ram_raddr = head_r;
      cqkr_pkg::RD_TAIL:  ram_raddr = tail_r;
      cqkr_pkg::RD_NEXT:  ram_raddr = scan_next;
      cqkr_pkg::RD_NEXT2: ram_raddr = next_slot(scan_next, cap_r);
      default:            ram_raddr = head_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts.req_type   = req_r.req_type;
    sts.empty      = (count_r == '0);
    sts.full       = (count_r >= cap_r);
    sts.match      = (((rd_word ^ req_r.key) & mask_r) == '0);
    sts.scan_last  = (CW'(scan_n_r + 1'b1) == count_r);
    sts.at_tail    = (scan_ptr_r == tail_r);
    sts.shift_last = (scan_next == tail_r);
  end

`ifndef SYNTH
  // The fill count never exceeds the capacity in use.
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r) else $error("fill count above capacity");

  // Ring pointers stay inside the slots in use.
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (XW'(head_r) < XW'(cap_r)) && (XW'(tail_r) < XW'(cap_r)))
    else $error("ring pointer outside capacity");

  // A completed removal drops exactly one entry.
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.retreat |=> count_r == $past(count_r) - 1'b1)
    else $error("removal did not drop one entry");
`endif

endmodule

// ===== rtl/core/cqkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqkr_ctrl: queue controller
// Sequences each request through dispatch, memory read, key search and
// entry shift, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cqkr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cqkr_pkg::sts_t sts,
  output cqkr_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_READ     = 6'b000100,
    S_SCAN     = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = cqkr_pkg::RD_HEAD;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.req_type) inside
          cqkr_pkg::REQ_ENQUEUE: begin
            cmd.enq   = !sts.full;
            cmd.fail  = sts.full;
            state_nxt = S_RESULT;
          end
          cqkr_pkg::REQ_DEQUEUE, cqkr_pkg::REQ_PEEK_FIRST: begin
            cmd.fail   = sts.empty;
            cmd.rd_en  = !sts.empty;
            cmd.rd_sel = cqkr_pkg::RD_HEAD;
            state_nxt  = sts.empty ? S_RESULT : S_READ;
          end
          cqkr_pkg::REQ_PEEK_LAST: begin
            cmd.fail   = sts.empty;
            cmd.rd_en  = !sts.empty;
            cmd.rd_sel = cqkr_pkg::RD_TAIL;
            state_nxt  = sts.empty ? S_RESULT : S_READ;
          end
          cqkr_pkg::REQ_REMOVE_KEY: begin
            cmd.fail      = sts.empty;
            cmd.rd_en     = !sts.empty;
            cmd.rd_sel    = cqkr_pkg::RD_HEAD;
            cmd.scan_init = !sts.empty;
            state_nxt     = sts.empty ? S_RESULT : S_SCAN;
          end
          default: begin
            cmd.fail  = 1'b1;
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_READ: begin
        cmd.capture = 1'b1;
        cmd.deq     = (sts.req_type == cqkr_pkg::REQ_DEQUEUE);
        state_nxt   = S_RESULT;
      end
      S_SCAN: begin
        // The word after the current one is always fetched; it feeds the
        // next compare or the first shift.
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cqkr_pkg::RD_NEXT;
        if (sts.match) begin
          cmd.capture = 1'b1;
          cmd.retreat = sts.at_tail;
          state_nxt   = sts.at_tail ? S_RESULT : S_SHIFT;
        end else if (sts.scan_last) begin
          cmd.fail  = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          cmd.retreat = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = cqkr_pkg::RD_NEXT2;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // An accepted transaction is dispatched in the next cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DISPATCH)
    else $error("accepted transaction not dispatched");

  // A result only appears after the result state loaded it.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result raised outside the result state");

  // A waiting result stays valid until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before it was taken");
`endif

endmodule

// ===== rtl/core/circular_queue_with_keyed_remove_unit.sv =====
// A request passes through the dispatch and result states for enqueue and failed requests,
// through dispatch, read and result for dequeue and peeks, and through dispatch, a search
// over the entries, a shift of the later entries and result for remove by key. One request
// at a time: the next input is accepted in the cycle the result turns valid, later while
// an earlier result waits to be taken. Reset: synchronous, active low; queue empty, capacity
// 16 (or DEPTH), match mask all ones; slot memory is not cleared.
// ----------------------------------------------------------------------------
// circular_queue_with_keyed_remove_unit: ring-buffer queue with keyed removal
// Top level joining the controller, the datapath and the slot memory.
// ----------------------------------------------------------------------------
module circular_queue_with_keyed_remove_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cqkr_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cqkr_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [cqkr_pkg::DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);

  cqkr_pkg::cmd_t         cmd;
  cqkr_pkg::sts_t         sts;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  // Request sequencer.
  cqkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Pointers, registers and result path.
  cqkr_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Slot storage.
  cqkr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
